>>> hw/rtl/smfd_pkg.sv
// Shared types, constants and the CRC-8 byte step for the measurement frame decoder.
package smfd_pkg;

   // Frame layout
   localparam int unsigned FRAME_BYTES = 9;
   localparam int unsigned POS_W       = 4;

   // Register indexes on the CSR port (byte address is 4 * index)
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam logic [1:0]  REG_CRC_POLY      = 2'd0;
   localparam logic [1:0]  REG_CRC_INIT      = 2'd1;
   localparam logic [1:0]  REG_CRC_FINAL_XOR = 2'd2;

   // Register reset values
   localparam logic [7:0] CRC_POLY_RST      = 8'h31;
   localparam logic [7:0] CRC_INIT_RST      = 8'hFF;
   localparam logic [7:0] CRC_FINAL_XOR_RST = 8'h00;

   // Scaling constants
   localparam logic [23:0] TEMP_SCALE  = 24'd175;
   localparam logic [23:0] HUM_SCALE   = 24'd100;
   localparam logic [8:0]  TEMP_OFFSET = 9'd45;

   // Status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_CO2_BAD  = 2'd1;
   localparam status_type ST_TEMP_BAD = 2'd2;
   localparam status_type ST_HUM_BAD  = 2'd3;

   // Byte role inside a three-byte group
   typedef enum logic [1:0] {
      PH_HIGH  = 2'd0,
      PH_LOW   = 2'd1,
      PH_CHECK = 2'd2
   } phase_type;

   // Word inside the frame
   typedef enum logic [1:0] {
      W_CO2  = 2'd0,
      W_TEMP = 2'd1,
      W_HUM  = 2'd2
   } word_type;

   // Feed one byte into an MSB-first CRC-8 with the top bit implicit
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/sensor_measurement_frame_decoder_top.sv
// Measurement frame decoder: CRC-8 check per word and scaling of CO2, temperature, humidity.
// Result path: the ninth byte is taken into the input register, then one pass of CRC step and
//   constant multiply loads the result register.
// Throughput: one byte per cycle, one result per nine bytes; a waiting result stalls intake
//   only while it is itself stalled and the ninth byte of the next frame sits in the input register.
// Reset: synchronous, active high; clears the byte count, error flag and both valid flags and
//   returns the CSRs to polynomial 0x31, initial value 0xFF, final XOR 0x00.
module sensor_measurement_frame_decoder_top (
   input  logic                      clock,
   input  logic                      reset,
   // Input byte channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_frame_start,
   // Result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_co2_ppm,
   output logic signed [8:0]         rsp_temperature_c,
   output logic [6:0]                rsp_humidity_pct,
   output smfd_pkg::status_type      rsp_status,
   // CSR port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [smfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import smfd_pkg::*;

   // CSRs
   logic [7:0] crc_poly_ff, crc_init_ff, crc_xor_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   // Input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       req_take;
   logic       advance;

   // Frame state
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       high_ff, high_in;
   logic [15:0]      held_co2_ff, held_co2_in;
   logic [7:0]       held_temp_ff, held_temp_in;
   status_type       first_err_ff, first_err_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_co2_ff, rsp_co2_in;
   logic [8:0]       rsp_temp_ff, rsp_temp_in;
   logic [6:0]       rsp_hum_ff, rsp_hum_in;
   status_type       rsp_status_ff, rsp_status_in;

   // Datapath helpers
   logic [POS_W-1:0] pos;
   status_type       err_base;
   phase_type        phase;
   word_type         word;
   logic [15:0]      word_val;
   logic [23:0]      temp_prod, hum_prod;
   logic [7:0]       crc_step;
   logic             last_byte;

   // CSR decode; pready is tied high
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      case (csr_idx)
         REG_CRC_POLY:      prdata = {24'd0, crc_poly_ff};
         REG_CRC_INIT:      prdata = {24'd0, crc_init_ff};
         REG_CRC_FINAL_XOR: prdata = {24'd0, crc_xor_ff};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff <= CRC_POLY_RST;
         crc_init_ff <= CRC_INIT_RST;
         crc_xor_ff  <= CRC_FINAL_XOR_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_CRC_POLY:      crc_poly_ff <= pwdata[7:0];
            REG_CRC_INIT:      crc_init_ff <= pwdata[7:0];
            REG_CRC_FINAL_XOR: crc_xor_ff  <= pwdata[7:0];
            default:           ;
         endcase
      end
   end

   // Handshake: advance any held byte but the last freely; the last needs the result slot
   // free or being drained
   assign advance   = in_valid_ff && (!last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Position in frame; frame start restarts count and error flag
   always_comb begin
      if (in_start_ff || (byte_pos_ff >= POS_W'(FRAME_BYTES))) begin
         pos = '0;
      end else begin
         pos = byte_pos_ff;
      end
      err_base  = in_start_ff ? ST_OK : first_err_ff;
      last_byte = (pos == POS_W'(FRAME_BYTES - 1));
   end

   // Split position into byte role and word
   always_comb begin
      case (pos)
         4'd0:    begin phase = PH_HIGH;  word = W_CO2;  end
         4'd1:    begin phase = PH_LOW;   word = W_CO2;  end
         4'd2:    begin phase = PH_CHECK; word = W_CO2;  end
         4'd3:    begin phase = PH_HIGH;  word = W_TEMP; end
         4'd4:    begin phase = PH_LOW;   word = W_TEMP; end
         4'd5:    begin phase = PH_CHECK; word = W_TEMP; end
         4'd6:    begin phase = PH_HIGH;  word = W_HUM;  end
         4'd7:    begin phase = PH_LOW;   word = W_HUM;  end
         4'd8:    begin phase = PH_CHECK; word = W_HUM;  end
         default: begin phase = PH_HIGH;  word = W_CO2;  end
      endcase
   end

   // CRC step and scaling
   assign crc_step  = crc8_feed((phase == PH_HIGH) ? crc_init_ff : crc_ff, in_byte_ff,
                                crc_poly_ff);
   assign word_val  = {high_ff, in_byte_ff};
   assign temp_prod = 24'(word_val) * TEMP_SCALE;
   assign hum_prod  = 24'(word_val) * HUM_SCALE;

   // Next frame state and result
   always_comb begin
      byte_pos_in   = byte_pos_ff;
      crc_in        = crc_ff;
      high_in       = high_ff;
      held_co2_in   = held_co2_ff;
      held_temp_in  = held_temp_ff;
      first_err_in  = first_err_ff;
      rsp_co2_in    = rsp_co2_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_hum_in    = rsp_hum_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (advance) begin
         first_err_in = err_base;
         case (phase)
            PH_HIGH: begin
               crc_in  = crc_step;
               high_in = in_byte_ff;
            end
            PH_LOW: begin
               crc_in = crc_step;
               case (word)
                  W_CO2:   held_co2_in  = word_val;
                  W_TEMP:  held_temp_in = temp_prod[23:16];
                  default: high_in      = hum_prod[23:16];
               endcase
            end
            default: begin
               if ((in_byte_ff != (crc_ff ^ crc_xor_ff)) && (err_base == ST_OK)) begin
                  first_err_in = status_type'(word) + 2'd1;
               end
               crc_in = crc_init_ff;
            end
         endcase

         if (last_byte) begin
            // Fields at or after the first failed word read zero
            rsp_valid_in  = 1'b1;
            rsp_status_in = first_err_in;
            rsp_co2_in    = (first_err_in != ST_CO2_BAD) ? held_co2_ff : 16'd0;
            rsp_temp_in   = ((first_err_in == ST_OK) || (first_err_in == ST_HUM_BAD)) ?
                            ({1'b0, held_temp_ff} - TEMP_OFFSET) : 9'd0;
            rsp_hum_in    = (first_err_in == ST_OK) ? high_ff[6:0] : 7'd0;
            byte_pos_in   = '0;
            first_err_in  = ST_OK;
         end else begin
            byte_pos_in = pos + POS_W'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         crc_ff       <= CRC_INIT_RST;
         high_ff      <= 8'd0;
         held_co2_ff  <= 16'd0;
         held_temp_ff <= 8'd0;
         first_err_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         crc_ff       <= crc_in;
         high_ff      <= high_in;
         held_co2_ff  <= held_co2_in;
         held_temp_ff <= held_temp_in;
         first_err_ff <= first_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_co2_ff    <= rsp_co2_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_hum_ff    <= rsp_hum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_co2_ppm       = rsp_co2_ff;
   assign rsp_temperature_c = $signed(rsp_temp_ff);
   assign rsp_humidity_pct  = rsp_hum_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> hw/rtl/smfd_checker.sv
// Port-level checks for the measurement frame decoder, bound to the top level.
module smfd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [15:0]               rsp_co2_ppm,
   input logic signed [8:0]         rsp_temperature_c,
   input logic [6:0]                rsp_humidity_pct,
   input smfd_pkg::status_type      rsp_status
);
   import smfd_pkg::*;

   // Stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_co2_ppm) &&
         $stable(rsp_temperature_c) && $stable(rsp_humidity_pct) && $stable(rsp_status))
      else $error("result changed while stalled");

   // Bad CO2 word zeroes every field
   a_co2_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_CO2_BAD) |->
         (rsp_co2_ppm == 16'd0) && (rsp_temperature_c == 9'sd0) && (rsp_humidity_pct == 7'd0))
      else $error("fields not cleared after CO2 CRC failure");

   // Bad temperature word zeroes temperature and humidity
   a_temp_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TEMP_BAD) |->
         (rsp_temperature_c == 9'sd0) && (rsp_humidity_pct == 7'd0))
      else $error("fields not cleared after temperature CRC failure");

   // Good frame stays inside the scaled ranges
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) |->
         (rsp_humidity_pct < 7'd100) && (rsp_temperature_c >= -9'sd45) &&
         (rsp_temperature_c <= 9'sd129))
      else $error("scaled value out of range");

endmodule

bind sensor_measurement_frame_decoder_top smfd_checker u_smfd_checker (.*);
